@@ design/http_response_header_matcher_core_defines.svh @@
// Assertion macros used by the header matcher core.
// Define ASSERT_OFF to compile the checks out.
`ifndef HTTP_RESPONSE_HEADER_MATCHER_CORE_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_MATCHER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define HRHM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define HRHM_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define HRHM_ASSERT(label, clk, rst_n, prop)
`define HRHM_ASSERT_NR(label, clk, prop)
`endif
`endif

@@ design/hrhm_pkg.sv @@
// Shared constants and types of the HTTP response header matcher.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hrhm_pkg;
  localparam int NAME_SLOTS = 4;
  localparam int NAME_MAX   = 32;
  localparam int VALUE_MAX  = 256;
  localparam int SLOT_W     = 2;
  localparam int POS_W      = 5;
  localparam int TBL_DEPTH  = NAME_SLOTS * NAME_MAX;
  localparam int TBL_AW     = 7;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [3:0] STATUS_LEN = 4'd12;

  typedef enum logic [1:0] {
    KIND_VALUE  = 2'd0,
    KIND_FOUND  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [1:0] slot;
    logic [7:0] vbyte;
    logic [8:0] vlen;
    logic       all_found;
    logic [9:0] code;
    logic       code_ok;
  } res_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction
endpackage
`default_nettype wire

@@ design/hrhm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hrhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

@@ design/http_response_header_matcher_core.sv @@
// Top level of the HTTP response header matcher.
// Depends on hrhm_pkg, hrhm_ram and http_response_header_matcher_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "http_response_header_matcher_core_defines.svh"
// One input beat per cycle while results drain. A name-load beat gives no
// result; a response byte gives zero, one or two results (a value byte or a
// line summary, then the status on the last byte), in the cycle after it is
// taken. Names sit in one RAM per slot (32 bytes each); the RAM is read at
// the next name position as a byte is taken, so a byte compares against data
// fetched while the previous byte was in flight. A load to the fetched address
// is bypassed, so a byte right behind a load sees the new character with no
// stall. Results wait in a two-entry output queue. Input is taken when the queue
// is empty, or when it holds one result that leaves in the same cycle. A byte
// that gives two results holds the input while the queue is full, as does every
// cycle with out_ready low and a result waiting. Nothing is taken during reset.
module http_response_header_matcher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_active_slots,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_response,
  input  wire logic [1:0]  in_slot_index,
  input  wire logic [4:0]  in_char_pos,
  input  wire logic        in_name_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic [1:0]       out_match_slot,
  output logic [7:0]       out_value_byte,
  output logic [8:0]       out_value_length,
  output logic             out_all_found,
  output logic [9:0]       out_status_code,
  output logic             out_status_valid,
  output logic             out_last_of_run
);
  localparam int NS = hrhm_pkg::NAME_SLOTS;

  // configuration
  logic [2:0] active_r;
  assign cfg_ready = rst_n;

  // name table: one RAM per slot, indexed by char position
  logic [NS-1:0] ram_we;
  logic [4:0]    ram_raddr;
  logic [7:0]    ram_rdata [NS];
  logic [5:0]    name_len_r [NS];

  // per-response state
  logic [NS-1:0] match_r;
  logic          after_colon_r, skip_r, prev_cr_r;
  logic [8:0]    npos_r;
  logic          lslot_vld_r;
  logic [1:0]    lslot_r;
  logic          pend_vld_r;
  logic [7:0]    pend_r;
  logic [8:0]    vcnt_r;
  logic [7:0]    found_r;
  logic          hdone_r;
  logic [3:0]    bpos_r;
  logic [9:0]    acc_r;
  logic          sok_r;

  // fetched-name bypass
  logic          fetch_hit_r [NS];
  logic [7:0]    fetch_byte_r [NS];

  // output queue
  hrhm_pkg::res_t q_r [2];
  logic [1:0]     q_cnt_r;

  logic in_acc, is_byte, is_load;
  assign is_load = in_req_type;
  assign is_byte = !in_req_type;
  // worst case two results per beat: take input only when both entries are free
  assign in_ready = rst_n && ((q_cnt_r == 2'd0) || (q_cnt_r == 2'd1 && out_ready));
  assign in_acc = in_valid && in_ready;

  // effective slot count
  logic [2:0] eff;
  assign eff = (active_r > 3'(NS)) ? 3'(NS) : active_r;

  // name char of current position per slot
  logic [7:0] cur_name [NS];
  always_comb begin
    for (int s = 0; s < NS; s++)
      cur_name[s] = fetch_hit_r[s] ? fetch_byte_r[s] : ram_rdata[s];
  end

  // header processing (combinational from current beat)
  logic [NS-1:0] match_nxt;
  logic          after_colon_nxt, skip_nxt, lslot_vld_nxt, pend_vld_nxt, hdone_nxt;
  logic [8:0]    npos_nxt, vcnt_nxt;
  logic [1:0]    lslot_nxt;
  logic [7:0]    pend_nxt, found_nxt;
  logic [3:0]    bpos_nxt;
  logic [9:0]    acc_nxt;
  logic          sok_nxt;
  hrhm_pkg::res_t r0, r1;
  logic [7:0]    b;
  logic          sel_found;
  logic [1:0]    sel_slot;

  assign b = in_data_byte;

  always_comb begin
    match_nxt = match_r; after_colon_nxt = after_colon_r; skip_nxt = skip_r;
    lslot_vld_nxt = lslot_vld_r; lslot_nxt = lslot_r; pend_vld_nxt = pend_vld_r;
    pend_nxt = pend_r; vcnt_nxt = vcnt_r; found_nxt = found_r; hdone_nxt = hdone_r;
    npos_nxt = npos_r; bpos_nxt = bpos_r; acc_nxt = acc_r; sok_nxt = sok_r;
    r0 = '0; r1 = '0; sel_found = 1'b0; sel_slot = '0;
    // status line
    if (bpos_r < hrhm_pkg::STATUS_LEN) begin
      case (bpos_r)
        4'd0: if (b != 8'h48) sok_nxt = 1'b0;
        4'd1, 4'd2: if (b != 8'h54) sok_nxt = 1'b0;
        4'd3: if (b != 8'h50) sok_nxt = 1'b0;
        4'd4: if (b != 8'h2F) sok_nxt = 1'b0;
        4'd6: if (b != 8'h2E) sok_nxt = 1'b0;
        4'd8: if (b != 8'h20) sok_nxt = 1'b0;
        4'd9, 4'd10, 4'd11: begin
          if (b >= 8'h30 && b <= 8'h39) begin
            if (sok_r) acc_nxt = 10'((acc_r * 10) + 10'(b - 8'h30));
          end else sok_nxt = 1'b0;
        end
        default: ;
      endcase
      bpos_nxt = bpos_r + 4'd1;
    end
    // header search
    if (!hdone_r && eff != 3'd0) begin
      if (b == hrhm_pkg::CH_LF && prev_cr_r) begin
        if (!after_colon_r) begin
          if (npos_r == 9'd1) hdone_nxt = 1'b1;
        end else if (lslot_vld_r) begin
          found_nxt = (found_r < 8'd255) ? found_r + 8'd1 : found_r;
          r0.valid = 1'b1; r0.kind = hrhm_pkg::KIND_FOUND; r0.slot = lslot_r;
          r0.vlen = vcnt_r;
          r0.all_found = (found_nxt >= 8'(eff));
          if (found_nxt >= 8'(eff)) hdone_nxt = 1'b1;
        end
        after_colon_nxt = 1'b0; skip_nxt = 1'b0; npos_nxt = '0; lslot_vld_nxt = 1'b0;
        pend_vld_nxt = 1'b0; vcnt_nxt = '0; match_nxt = '1;
      end else if (!after_colon_r) begin
        if (b == hrhm_pkg::CH_COLON) begin
          after_colon_nxt = 1'b1; skip_nxt = 1'b1;
          for (int s = NS - 1; s >= 0; s--) begin
            if (3'(s) < eff && match_r[s] && 9'(name_len_r[s]) == npos_r) begin
              sel_found = 1'b1; sel_slot = 2'(s);
            end
          end
          lslot_vld_nxt = sel_found; lslot_nxt = sel_slot;
        end else begin
          for (int s = 0; s < NS; s++) begin
            if (!(npos_r < 9'(name_len_r[s]) && npos_r < 9'(hrhm_pkg::NAME_MAX) &&
                  hrhm_pkg::fold(cur_name[s]) == hrhm_pkg::fold(b)))
              match_nxt[s] = 1'b0;
          end
          if (npos_r < 9'd511) npos_nxt = npos_r + 9'd1;
        end
      end else if (skip_r) begin
        skip_nxt = 1'b0;
      end else begin
        if (pend_vld_r) begin
          if (lslot_vld_r) begin
            r0.valid = 1'b1; r0.kind = hrhm_pkg::KIND_VALUE; r0.slot = lslot_r;
            r0.vbyte = pend_r;
          end
          if (vcnt_r < 9'(hrhm_pkg::VALUE_MAX)) vcnt_nxt = vcnt_r + 9'd1;
        end
        pend_vld_nxt = 1'b1; pend_nxt = b;
      end
    end
    if (in_end_of_response) begin
      r1.valid = 1'b1; r1.kind = hrhm_pkg::KIND_STATUS;
      r1.code_ok = sok_nxt && (bpos_nxt >= hrhm_pkg::STATUS_LEN);
      r1.code = r1.code_ok ? acc_nxt : '0;
      after_colon_nxt = 1'b0; skip_nxt = 1'b0; npos_nxt = '0; lslot_vld_nxt = 1'b0;
      pend_vld_nxt = 1'b0; vcnt_nxt = '0; match_nxt = '1;
      found_nxt = '0; hdone_nxt = 1'b0; bpos_nxt = '0; acc_nxt = '0; sok_nxt = 1'b1;
    end
  end

  // name RAM fetch address: position the next byte will compare against
  logic [8:0] fetch_pos;
  always_comb begin
    fetch_pos = npos_r;
    if (in_acc && is_byte) fetch_pos = npos_nxt;
  end
  assign ram_raddr = fetch_pos[4:0];

  for (genvar s = 0; s < NS; s++) begin : g_slot
    assign ram_we[s] = in_acc && is_load && in_slot_index == 2'(s);
    hrhm_ram #(.WIDTH(8), .DEPTH(hrhm_pkg::NAME_MAX)) u_name (
      .clk(clk), .we(ram_we[s]), .waddr(in_char_pos), .wdata(in_data_byte),
      .raddr(ram_raddr), .rdata(ram_rdata[s]));
    // a load to the address fetched this cycle wins over the stale read
    always_ff @(posedge clk) begin
      fetch_hit_r[s]  <= ram_we[s] && in_char_pos == ram_raddr;
      fetch_byte_r[s] <= in_data_byte;
    end
  end

  // queue push of this beat's results, packed in order
  hrhm_pkg::res_t p0, p1;
  logic [1:0] npush;
  always_comb begin
    p0 = r0.valid ? r0 : r1;
    p1 = r1;
    npush = 2'(r0.valid) + 2'(r1.valid);
    if (!(in_acc && is_byte)) npush = 2'd0;
  end

  logic pop;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0; match_r <= '1; after_colon_r <= 1'b0; skip_r <= 1'b0;
      prev_cr_r <= 1'b0; npos_r <= '0; lslot_vld_r <= 1'b0; pend_vld_r <= 1'b0;
      vcnt_r <= '0; found_r <= '0; hdone_r <= 1'b0; bpos_r <= '0; acc_r <= '0;
      sok_r <= 1'b1; q_cnt_r <= '0;
      for (int s = 0; s < NS; s++) name_len_r[s] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) active_r <= cfg_active_slots;
      if (in_acc && is_load && in_name_end)
        name_len_r[in_slot_index] <= 6'(in_char_pos) + 6'd1;
      if (in_acc && is_byte) begin
        match_r <= match_nxt; after_colon_r <= after_colon_nxt; skip_r <= skip_nxt;
        prev_cr_r <= (b == hrhm_pkg::CH_CR) && !in_end_of_response;
        npos_r <= npos_nxt; lslot_vld_r <= lslot_vld_nxt; lslot_r <= lslot_nxt;
        pend_vld_r <= pend_vld_nxt; pend_r <= pend_nxt; vcnt_r <= vcnt_nxt;
        found_r <= found_nxt; hdone_r <= hdone_nxt; bpos_r <= bpos_nxt;
        acc_r <= acc_nxt; sok_r <= sok_nxt;
      end
      // queue: drop head on pop, append new results behind
      begin
        hrhm_pkg::res_t a0, a1;
        logic [1:0] c;
        a0 = q_r[0]; a1 = q_r[1]; c = q_cnt_r;
        if (pop) begin a0 = a1; c = c - 2'd1; end
        if (npush != 2'd0) begin
          if (c == 2'd0) begin a0 = p0; a1 = p1; end
          else a1 = p0;
        end
        q_r[0] <= a0; q_r[1] <= a1;
        q_cnt_r <= c + npush;
      end
    end
  end

  assign out_valid        = q_cnt_r != 2'd0;
  assign out_result_kind  = q_r[0].kind;
  assign out_match_slot   = q_r[0].slot;
  assign out_value_byte   = q_r[0].vbyte;
  assign out_value_length = q_r[0].vlen;
  assign out_all_found    = q_r[0].all_found;
  assign out_status_code  = q_r[0].code;
  assign out_status_valid = q_r[0].code_ok;
  // last of run: head alone, or second entry is not from the same beat
  assign out_last_of_run  = !(q_cnt_r == 2'd2 && q_r[1].kind == hrhm_pkg::KIND_STATUS &&
                              q_r[0].kind != hrhm_pkg::KIND_STATUS);

  `HRHM_ASSERT(a_q_bound, clk, rst_n, q_cnt_r != 2'd3)
  `HRHM_ASSERT(a_no_overflow, clk, rst_n, (in_valid && in_ready) |-> q_cnt_r != 2'd2)
  `HRHM_ASSERT(a_pend_after_colon, clk, rst_n, pend_vld_r |-> after_colon_r)
  `HRHM_ASSERT(a_slot_after_colon, clk, rst_n, lslot_vld_r |-> after_colon_r)
endmodule
`default_nettype wire
